// ----- hw/rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants and types for the bubble sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int COUNT = 8;
  localparam int IDX_W = $clog2(COUNT);
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [DATA_W-1:0] value_t;

  localparam idx_t LAST_IDX = idx_t'(COUNT - 1);
  localparam idx_t FINAL_PASS = idx_t'(COUNT - 2);

  typedef struct packed {
    logic load;
    logic last;
  } emit_t;

endpackage

// ----- hw/rtl/bubble_sort_engine.sv -----
// ----------------------------------------------------------------------------
// bubble_sort_engine
// Collects COUNT signed values and returns them sorted in ascending order.
// ----------------------------------------------------------------------------
// The slave channel takes one signed 32-bit value per request, one request a
// cycle while loading. After COUNT values the input stalls while the block
// sorts its store by bubble sort through a single compare unit and a store
// with one write and one read port. Each pass over L neighbour pairs reads
// the first value, compares and writes back the pairs in turn while carrying
// the larger value, and ends by writing that value to the last place of the
// pass. The sorted values then leave on the master channel smallest first,
// one at a time, each read from the store only once the output register is
// free, with tlast on the final one. Loading of the next block starts as
// soon as the last result is in the output register. A stalled receiver
// holds the output register and the sequencer waits. Reset empties the block
// and drops the output request; the store contents are not cleared.
// ----------------------------------------------------------------------------
module bubble_sort_engine
  import bse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sorted_value
  output logic        m_tlast
);

  logic   we;
  idx_t   waddr;
  value_t wdata;
  idx_t   raddr;
  value_t rdata;
  emit_t  emit;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  bse_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (value_t'(s_tdata)),
    .out_free (out_free),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      m_tdata <= rdata;
      m_tlast <= emit.last;
    end
  end

endmodule

// ----- hw/rtl/bse_store.sv -----
// ----------------------------------------------------------------------------
// bse_store
// Element store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bse_store
  import bse_pkg::*;
(
  input  logic   clk,
  input  logic   we,
  input  idx_t   waddr,
  input  value_t wdata,
  input  idx_t   raddr,
  output value_t rdata
);

  value_t mem [COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bse_ctrl.sv -----
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer for loading, bubble passes through a shared compare unit, and
// read-out of the sorted store.
// ----------------------------------------------------------------------------
module bse_ctrl
  import bse_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  value_t in_value,
  input  logic   out_free,
  output logic   we,
  output idx_t   waddr,
  output value_t wdata,
  output idx_t   raddr,
  input  value_t rdata,
  output emit_t  emit
);

  typedef enum logic [2:0] {
    LOAD,
    RD0,
    CUR,
    CMP,
    TAIL,
    EMIT_WAIT,
    EMIT_RD,
    EMIT_LD
  } state_t;

  state_t state;
  idx_t   cnt;
  idx_t   pass;
  idx_t   j;
  idx_t   k;
  idx_t   lim;
  value_t cur;
  logic   swap;

  // The larger value of each pair is carried in cur to the end of the pass.
  assign lim  = LAST_IDX - pass;
  assign swap = cur > rdata;

  assign in_ready = (state == LOAD);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = in_value;
    raddr = k;
    unique case (state)
      LOAD: begin
        we = in_valid;
      end
      RD0: begin
        raddr = '0;
      end
      CUR: begin
        raddr = j + idx_t'(1);
      end
      CMP: begin
        we    = 1'b1;
        waddr = j;
        wdata = swap ? rdata : cur;
        raddr = j + idx_t'(2);
      end
      TAIL: begin
        we    = 1'b1;
        waddr = lim;
        wdata = cur;
      end
      default: begin
        raddr = k;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      cnt       <= '0;
      pass      <= '0;
      j         <= '0;
      k         <= '0;
      emit.load <= 1'b0;
      emit.last <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_valid) begin
            if (cnt == LAST_IDX) begin
              cnt   <= '0;
              pass  <= '0;
              state <= RD0;
            end else begin
              cnt <= cnt + idx_t'(1);
            end
          end
        end
        RD0: begin
          j     <= '0;
          state <= CUR;
        end
        CUR: begin
          cur   <= rdata;
          state <= CMP;
        end
        CMP: begin
          if (!swap) begin
            cur <= rdata;
          end
          if (j + idx_t'(1) == lim) begin
            state <= TAIL;
          end else begin
            j <= j + idx_t'(1);
          end
        end
        TAIL: begin
          if (pass == FINAL_PASS) begin
            k     <= '0;
            state <= EMIT_WAIT;
          end else begin
            pass  <= pass + idx_t'(1);
            state <= RD0;
          end
        end
        EMIT_WAIT: begin
          if (out_free) begin
            state <= EMIT_RD;
          end
        end
        EMIT_RD: begin
          emit.load <= 1'b1;
          emit.last <= (k == LAST_IDX);
          state     <= EMIT_LD;
        end
        EMIT_LD: begin
          emit.load <= 1'b0;
          if (k == LAST_IDX) begin
            state <= LOAD;
          end else begin
            k     <= k + idx_t'(1);
            state <= EMIT_WAIT;
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule
